/* sv/abm_pkg.sv */
// Package for the ASID bitmap allocator: sizes, codes and word types.
// No dependencies; every other file of the block uses it by scoped names.
package abm_pkg;

  // Map geometry: MAP_WORDS words of WORD_BITS bits, one bit per identifier.
  // WORD_BITS is a power of two.
  localparam int MAP_WORDS = 8;
  localparam int WORD_BITS = 32;
  localparam int MAP_IDS   = MAP_WORDS * WORD_BITS;

  localparam int IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W = $clog2(WORD_BITS);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FREED     = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_ZERO_IGN  = 2'd3
  } status_e;

  // Request word
  typedef struct packed {
    logic       opcode;
    logic [7:0] asid;
  } req_t;

  // Response word
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] asid_out;
    logic       tlb_invalidate;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;
    logic scan_step;
    logic commit_alloc;
    logic commit_exhaust;
    logic commit_free;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic found;
    logic last_word;
    logic slot_free;
  } sts_t;

endpackage

/* sv/asid_bitmap_allocator.sv */
// Top level of the ASID bitmap allocator: controller plus datapath.
// Depends on abm_pkg, abm_ctrl and abm_dp.
//
// Hands out address-space identifiers 1..255 from a 256-bit in-use map
// (eight 32-bit words) and frees them again. An allocate scans one map word
// per cycle starting at the word of the last allocated ID, wrapping around
// and visiting at most eight words; the result of an allocate or a free
// waits until the output register can take it. One request is in
// flight at a time. Results sit in an output register, so a finished result
// may wait for the consumer while the next request is already accepted. The
// map is cleared by reset; no clearing pass is needed.
module asid_bitmap_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  abm_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output abm_pkg::rsp_t out_data_o
);

  abm_pkg::cmd_t cmd;
  abm_pkg::sts_t sts;

  abm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  abm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* sv/abm_ctrl.sv */
// Controller for the ASID bitmap allocator: one request at a time.
// Depends on abm_pkg; drives abm_dp through cmd_t and reads sts_t.
module abm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_opcode_i,
  output logic          in_ready_o,
  input  abm_pkg::sts_t sts_i,
  output abm_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FREE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          if (in_opcode_i == abm_pkg::OP_ALLOC) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_FREE;
          end
        end
      end
      S_SCAN: begin
        // one map word per cycle; finish waits for an open output slot
        if (sts_i.found) begin
          if (sts_i.slot_free) begin
            cmd_o.commit_alloc = 1'b1;
            state_d            = S_IDLE;
          end
        end else if (sts_i.last_word) begin
          if (sts_i.slot_free) begin
            cmd_o.commit_exhaust = 1'b1;
            state_d              = S_IDLE;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_FREE: begin
        if (sts_i.slot_free) begin
          cmd_o.commit_free = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/abm_dp.sv */
// Datapath for the ASID bitmap allocator: in-use map, hint, scan pointer,
// first-clear-bit search and the output register. Depends on abm_pkg.
module abm_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  abm_pkg::req_t in_data_i,
  input  abm_pkg::cmd_t cmd_i,
  output abm_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output abm_pkg::rsp_t out_data_o
);

  localparam int IDX_W = abm_pkg::IDX_W;
  localparam int BIT_W = abm_pkg::BIT_W;
  localparam int WB    = abm_pkg::WORD_BITS;
  localparam int MW    = abm_pkg::MAP_WORDS;

  logic [WB-1:0]    map_q [MW];
  logic [7:0]       hint_q;
  logic [7:0]       req_asid_q;
  logic [IDX_W-1:0] word_q, word_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  abm_pkg::rsp_t    out_q, out_d;

  // Start word of a scan: the hint's word index (always inside the map)
  logic [IDX_W+7:0] hint_wide;
  logic [IDX_W-1:0] start_word;
  assign hint_wide  = {{IDX_W{1'b0}}, hint_q};
  assign start_word = hint_wide[BIT_W +: IDX_W];

  // Clear-bit candidates of the current word; ID 0 is never handed out
  logic [WB-1:0]    cand;
  logic [BIT_W-1:0] hit_bit;
  logic             found;
  always_comb begin
    cand = ~map_q[word_q];
    if (word_q == '0) begin
      cand[0] = 1'b0;
    end
    hit_bit = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit_bit = BIT_W'(b);
      end
    end
    found = |cand;
  end

  // Allocated ID, kept to its low 8 bits
  logic [IDX_W+BIT_W+7:0] got_wide;
  logic [7:0]             got_id;
  assign got_wide = {8'b0, word_q, hit_bit};
  assign got_id   = got_wide[7:0];

  // Free target
  logic [IDX_W+7:0] id_wide;
  logic [IDX_W-1:0] free_word;
  logic [BIT_W-1:0] free_bit;
  logic             free_in_map;
  logic             free_zero;
  assign id_wide     = {{IDX_W{1'b0}}, req_asid_q};
  assign free_word   = id_wide[BIT_W +: IDX_W];
  assign free_bit    = req_asid_q[BIT_W-1:0];
  assign free_in_map = ({24'b0, req_asid_q} < 32'(abm_pkg::MAP_IDS));
  assign free_zero   = (req_asid_q == 8'd0);

  // Status to the controller
  logic pop;
  assign pop              = out_valid_q && out_ready_i;
  assign sts_o.found      = found;
  assign sts_o.last_word  = (cnt_q == IDX_W'(MW - 1));
  assign sts_o.slot_free  = !out_valid_q || out_ready_i;

  // Scan pointer and visited-word count
  always_comb begin
    word_d = word_q;
    cnt_d  = cnt_q;
    if (cmd_i.load_req) begin
      word_d = start_word;
      cnt_d  = '0;
    end else if (cmd_i.scan_step) begin
      word_d = (word_q == IDX_W'(MW - 1)) ? '0 : word_q + 1'b1;
      cnt_d  = cnt_q + 1'b1;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !pop;
    out_d       = out_q;
    if (cmd_i.commit_alloc) begin
      out_valid_d          = 1'b1;
      out_d.status         = abm_pkg::ST_ALLOCATED;
      out_d.asid_out       = got_id;
      out_d.tlb_invalidate = 1'b0;
    end else if (cmd_i.commit_exhaust) begin
      out_valid_d          = 1'b1;
      out_d.status         = abm_pkg::ST_EXHAUSTED;
      out_d.asid_out       = 8'd0;
      out_d.tlb_invalidate = 1'b0;
    end else if (cmd_i.commit_free) begin
      out_valid_d          = 1'b1;
      out_d.asid_out       = 8'd0;
      if (free_zero) begin
        out_d.status         = abm_pkg::ST_ZERO_IGN;
        out_d.tlb_invalidate = 1'b0;
      end else begin
        out_d.status         = abm_pkg::ST_FREED;
        out_d.tlb_invalidate = 1'b1;
      end
    end
  end

  // Map and hint
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < MW; w++) begin
        map_q[w] <= '0;
      end
      hint_q <= '0;
    end else if (cmd_i.commit_alloc) begin
      map_q[word_q][hit_bit] <= 1'b1;
      hint_q                 <= got_id;
    end else if (cmd_i.commit_free && !free_zero && free_in_map) begin
      map_q[free_word][free_bit] <= 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      word_q      <= '0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      word_q      <= word_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.load_req) begin
      req_asid_q <= in_data_i.asid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
